@@ rtl/u8tok_pkg.sv @@
package u8tok_pkg;

   localparam int COUNT_WIDTH_DEFAULT = 16;
   localparam int OUT_W = 16;

   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
   localparam int FIFO_LVL_W = $clog2(FIFO_DEPTH + 1);

   // token categories
   localparam logic [2:0] CAT_WORD    = 3'd0;
   localparam logic [2:0] CAT_PUNCT   = 3'd1;
   localparam logic [2:0] CAT_SPACE   = 3'd2;
   localparam logic [2:0] CAT_EOL     = 3'd3;
   localparam logic [2:0] CAT_UNKNOWN = 3'd4;

   localparam logic [7:0] BYTE_NL  = 8'h0A;
   localparam logic [7:0] BYTE_CR  = 8'h0D;
   localparam logic [7:0] BYTE_US  = 8'h5F;
   localparam logic [7:0] BYTE_SP  = 8'h20;
   localparam logic [7:0] BYTE_TAB = 8'h09;
   localparam logic [7:0] BYTE_DEL = 8'h7F;

   typedef struct packed {
      logic [7:0] text_byte;
      logic       end_of_text;
   } req_type;

   typedef struct packed {
      logic [2:0]       category;
      logic [OUT_W-1:0] byte_length;
      logic [OUT_W-1:0] char_count;
      logic             final_token;
   } rsp_type;

   typedef struct packed {
      logic [FIFO_LVL_W-1:0] level;
      logic                  empty;
   } fifo_status_type;

   // continuation bytes that follow a utf-8 lead byte
   function automatic logic [2:0] follower_count(input logic [7:0] b);
      logic [2:0] n;
      n = 3'd0;
      priority casez (b)
         8'b11111111: n = 3'd7;
         8'b11111110: n = 3'd6;
         8'b1111110?: n = 3'd5;
         8'b111110??: n = 3'd4;
         8'b11110???: n = 3'd3;
         8'b1110????: n = 3'd2;
         8'b110?????: n = 3'd1;
         default:     n = 3'd0;
      endcase
      return n;
   endfunction

   function automatic logic is_alnum(input logic [7:0] b);
      return (b >= "0" && b <= "9") || (b >= "A" && b <= "Z") || (b >= "a" && b <= "z");
   endfunction

   function automatic logic is_space(input logic [7:0] b);
      return (b == BYTE_SP) || (b >= BYTE_TAB && b <= BYTE_CR);
   endfunction

endpackage

@@ rtl/u8tok_step.sv @@
module u8tok_step #(
   parameter int CNT_W = 16
) (
   input  u8tok_pkg::req_type  req_data,
   input  logic                open_cur,
   input  logic [2:0]          cat_cur,
   input  logic [CNT_W-1:0]    len_cur,
   input  logic [CNT_W-1:0]    chars_cur,
   input  logic [2:0]          skip_cur,
   output logic                open_nxt,
   output logic [2:0]          cat_nxt,
   output logic [CNT_W-1:0]    len_nxt,
   output logic [CNT_W-1:0]    chars_nxt,
   output logic [2:0]          skip_nxt,
   output u8tok_pkg::rsp_type  res [2],
   output logic [1:0]          res_count
);
   import u8tok_pkg::*;

   logic [7:0] b;
   logic       eol_byte;
   logic       word_alnum;
   logic       taken;
   logic [1:0] n;

   function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
      return (&v) ? v : v + CNT_W'(1);
   endfunction

   assign b          = req_data.text_byte;
   assign eol_byte   = (b == BYTE_NL) || (b == BYTE_CR);
   assign word_alnum = is_alnum(b) || (b == BYTE_US);

   always_comb begin
      open_nxt  = open_cur;
      cat_nxt   = cat_cur;
      len_nxt   = len_cur;
      chars_nxt = chars_cur;
      skip_nxt  = skip_cur;
      res[0]    = '0;
      res[1]    = '0;
      taken     = 1'b0;
      n         = 2'd0;

      // try to extend the open token
      if (open_cur) begin
         priority if (cat_cur == CAT_WORD) begin
            if (skip_cur != 3'd0) begin
               skip_nxt = skip_cur - 3'd1;
               len_nxt  = sat_inc(len_cur);
               taken    = 1'b1;
            end else if ((b[7:6] == 2'b11) || word_alnum) begin
               len_nxt   = sat_inc(len_cur);
               chars_nxt = sat_inc(chars_cur);
               skip_nxt  = follower_count(b);
               taken     = 1'b1;
            end
         end else if (cat_cur == CAT_EOL) begin
            if (eol_byte) begin
               len_nxt = sat_inc(len_cur);
               if (b == BYTE_NL) begin
                  chars_nxt = sat_inc(chars_cur);
               end
               taken = 1'b1;
            end
         end else if (cat_cur == CAT_SPACE) begin
            if (is_space(b)) begin
               len_nxt   = sat_inc(len_cur);
               chars_nxt = sat_inc(chars_cur);
               taken     = 1'b1;
            end
         end else begin
            taken = 1'b0;
         end
         if (!taken) begin
            res[0] = '{category: cat_cur, byte_length: OUT_W'(len_cur),
                       char_count: OUT_W'(chars_cur), final_token: 1'b0};
            n         = 2'd1;
            open_nxt  = 1'b0;
            cat_nxt   = CAT_WORD;
            len_nxt   = '0;
            chars_nxt = '0;
            skip_nxt  = 3'd0;
         end
      end

      // start a new token from this byte
      if (!taken) begin
         priority if (b[7] || word_alnum) begin
            open_nxt  = 1'b1;
            cat_nxt   = CAT_WORD;
            len_nxt   = CNT_W'(1);
            chars_nxt = CNT_W'(1);
            skip_nxt  = follower_count(b);
         end else if (eol_byte) begin
            open_nxt  = 1'b1;
            cat_nxt   = CAT_EOL;
            len_nxt   = CNT_W'(1);
            chars_nxt = '0;
            skip_nxt  = 3'd0;
         end else if (is_space(b)) begin
            open_nxt  = 1'b1;
            cat_nxt   = CAT_SPACE;
            len_nxt   = CNT_W'(1);
            chars_nxt = CNT_W'(1);
            skip_nxt  = 3'd0;
         end else if (b > BYTE_SP && b < BYTE_DEL) begin
            res[n[0]] = '{category: CAT_PUNCT, byte_length: OUT_W'(1),
                          char_count: OUT_W'(1), final_token: 1'b0};
            n = n + 2'd1;
         end else begin
            res[n[0]] = '{category: CAT_UNKNOWN, byte_length: OUT_W'(1),
                          char_count: OUT_W'(0), final_token: 1'b0};
            n = n + 2'd1;
         end
      end

      // end of text flushes and returns to the reset state
      if (req_data.end_of_text) begin
         if (open_nxt) begin
            res[n[0]] = '{category: cat_nxt, byte_length: OUT_W'(len_nxt),
                          char_count: OUT_W'(chars_nxt), final_token: 1'b0};
            n = n + 2'd1;
         end
         if (n != 2'd0) begin
            res[n[0] ^ 1'b1].final_token = 1'b1;
         end
         open_nxt  = 1'b0;
         cat_nxt   = CAT_WORD;
         len_nxt   = '0;
         chars_nxt = '0;
         skip_nxt  = 3'd0;
      end

      res_count = n;
   end

endmodule

@@ rtl/u8tok_fifo.sv @@
module u8tok_fifo (
   input  logic                        clock,
   input  logic                        reset,
   input  u8tok_pkg::rsp_type          push_data [2],
   input  logic [1:0]                  push_count,
   input  logic                        pop,
   output u8tok_pkg::rsp_type          head,
   output u8tok_pkg::fifo_status_type  status
);
   import u8tok_pkg::*;

   rsp_type               mem_ff [FIFO_DEPTH];
   logic [FIFO_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [FIFO_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [FIFO_LVL_W-1:0] level_ff, level_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff + FIFO_PTR_W'(push_count);
      rd_ptr_in = rd_ptr_ff + FIFO_PTR_W'(pop);
      level_in  = level_ff + FIFO_LVL_W'(push_count) - FIFO_LVL_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         level_ff  <= level_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_count != 2'd0) begin
         mem_ff[wr_ptr_ff] <= push_data[0];
      end
      if (push_count == 2'd2) begin
         mem_ff[wr_ptr_ff + FIFO_PTR_W'(1)] <= push_data[1];
      end
   end

   assign head         = mem_ff[rd_ptr_ff];
   assign status.level = level_ff;
   assign status.empty = (level_ff == '0);

endmodule

@@ rtl/utf8_word_tokenizer_unit.sv @@
// utf-8 word tokenizer: takes one text byte per request and cuts the stream into
// word, punctuation, whitespace, end-of-line and unknown tokens, each delivered
// as category, byte length, character count and a final flag. the byte class
// decode and the counter update sit in one short combinational step between the
// request port and a four-entry response queue, so a byte is taken in every cycle
// while req_stall is low and its responses go into the queue. most bytes give no
// response or one; a byte that closes a token and also yields another gives two,
// and since the response port moves one per cycle while rsp_stall is low, text
// of such bytes fills the queue. req_stall rises whenever the queue has fewer than
// two free entries. counts saturate at the smaller of 2^COUNT_WIDTH-1 and 65535.
module utf8_word_tokenizer_unit #(
   parameter int COUNT_WIDTH = u8tok_pkg::COUNT_WIDTH_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  u8tok_pkg::req_type  req_data,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output u8tok_pkg::rsp_type  rsp_data
);
   import u8tok_pkg::*;

   // counters never need more than the 16 bits of the response fields
   localparam int CntW = (COUNT_WIDTH < OUT_W) ? COUNT_WIDTH : OUT_W;

   // open token state
   logic            open_ff,  open_in;
   logic [2:0]      cat_ff,   cat_in;
   logic [CntW-1:0] len_ff,   len_in;
   logic [CntW-1:0] chars_ff, chars_in;
   logic [2:0]      skip_ff,  skip_in;

   rsp_type         step_res [2];
   logic [1:0]      step_count;
   logic [1:0]      push_count;
   logic            req_accept;
   logic            rsp_accept;
   fifo_status_type fifo_status;

   assign req_accept = req_valid && !req_stall;
   assign rsp_accept = rsp_valid && !rsp_stall;

   // room for the worst case of two responses per request
   assign req_stall  = fifo_status.level > FIFO_LVL_W'(FIFO_DEPTH - 2);
   assign rsp_valid  = !fifo_status.empty;
   assign push_count = req_accept ? step_count : 2'd0;

   // class decode and token update for the incoming byte
   u8tok_step #(
      .CNT_W(CntW)
   ) u_step (
      .req_data  (req_data),
      .open_cur  (open_ff),
      .cat_cur   (cat_ff),
      .len_cur   (len_ff),
      .chars_cur (chars_ff),
      .skip_cur  (skip_ff),
      .open_nxt  (open_in),
      .cat_nxt   (cat_in),
      .len_nxt   (len_in),
      .chars_nxt (chars_in),
      .skip_nxt  (skip_in),
      .res       (step_res),
      .res_count (step_count)
   );

   // state only moves when a request is taken
   always_ff @(posedge clock) begin
      if (reset) begin
         open_ff  <= 1'b0;
         cat_ff   <= CAT_WORD;
         len_ff   <= '0;
         chars_ff <= '0;
         skip_ff  <= 3'd0;
      end else if (req_accept) begin
         open_ff  <= open_in;
         cat_ff   <= cat_in;
         len_ff   <= len_in;
         chars_ff <= chars_in;
         skip_ff  <= skip_in;
      end
   end

   // response queue parts the two sides
   u8tok_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_data  (step_res),
      .push_count (push_count),
      .pop        (rsp_accept),
      .head       (rsp_data),
      .status     (fifo_status)
   );

`ifndef SYNTH
   // the queue never holds more than its depth
   a_fifo_bound: assert property (@(posedge clock) disable iff (reset)
      fifo_status.level <= FIFO_LVL_W'(FIFO_DEPTH))
      else $error("response queue overrun");

   // the end of text leaves no token open
   a_eot_closes: assert property (@(posedge clock) disable iff (reset)
      req_accept && req_data.end_of_text |=> !open_ff && skip_ff == 3'd0)
      else $error("token still open after end of text");

   // a closed state carries no leftover length or pending continuation bytes
   a_idle_clean: assert property (@(posedge clock) disable iff (reset)
      !open_ff |-> len_ff == '0 && chars_ff == '0 && skip_ff == 3'd0)
      else $error("stale token state while idle");

   // a word never counts more characters than bytes
   a_word_chars: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.category == CAT_WORD
      |-> rsp_data.char_count <= rsp_data.byte_length)
      else $error("word with more characters than bytes");
`endif

endmodule
